>>> rtl/core/fat12_fat16_entry_table_macros.svh
// ---------------------------------------------------------------------------
// fat12_fat16_entry_table assertion macros
// immediate and next-cycle implications, reset-qualified
// ---------------------------------------------------------------------------
`ifndef FAT12_FAT16_ENTRY_TABLE_MACROS_SVH
`define FAT12_FAT16_ENTRY_TABLE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define FATET_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FATET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/fatet_pkg.sv
// ---------------------------------------------------------------------------
// fatet_pkg
// shared types and constants for the cluster table store
// ---------------------------------------------------------------------------
package fatet_pkg;

	localparam int unsigned LIM_W  = 17;

	localparam logic [2:0] REG_FAT16_MODE = 3'd0;

	localparam logic [1:0] KIND_LOAD_BYTE  = 2'd0;
	localparam logic [1:0] KIND_READ_BYTE  = 2'd1;
	localparam logic [1:0] KIND_READ_ENTRY = 2'd2;
	localparam logic [1:0] KIND_WRITE_ENTRY = 2'd3;

	localparam logic [15:0] FAT16_BAD = 16'hfff7;
	localparam logic [15:0] FAT16_EOC = 16'hfff8;
	localparam logic [15:0] FAT12_BAD = 16'h0ff7;
	localparam logic [15:0] FAT12_EOC = 16'h0ff8;
	localparam logic [15:0] FAT12_MASK = 16'h0fff;

	typedef enum logic [2:0] {
		SEL_BYTE,
		SEL_LO,
		SEL_HI,
		SEL_NB,
		SEL_OTHER
	} addr_sel_t;

	typedef struct packed {
		logic      load_in;
		logic      mem_en;
		logic      mem_we;
		addr_sel_t addr_sel;
		logic      cap_lo;
		logic      load_out;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       fat16;
		logic       range_err;
	} status_t;

endpackage

>>> rtl/core/fatet_ctrl.sv
// ---------------------------------------------------------------------------
// fatet_ctrl
// sequencer for byte and entry accesses on the single-port table memory
// ---------------------------------------------------------------------------
`include "fat12_fat16_entry_table_macros.svh"

module fatet_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  fatet_pkg::status_t status,
	output fatet_pkg::cmd_t   cmd
);
	import fatet_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_RDB,
		S_RD_LO,
		S_RD_HI,
		S_RMW_RD,
		S_WR_A,
		S_WR_B,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   in_fire;
	logic   slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd          = '0;
		cmd.addr_sel = SEL_BYTE;
		case (state_q)
			S_IDLE: begin
				cmd.load_in = in_fire;
			end
			S_LOAD: begin
				cmd.mem_en = 1'b1;
				cmd.mem_we = 1'b1;
			end
			S_RDB: begin
				cmd.mem_en = 1'b1;
			end
			S_RD_LO: begin
				cmd.mem_en   = 1'b1;
				cmd.addr_sel = SEL_LO;
			end
			S_RD_HI: begin
				cmd.mem_en   = 1'b1;
				cmd.addr_sel = SEL_HI;
				cmd.cap_lo   = 1'b1;
			end
			S_RMW_RD: begin
				cmd.mem_en   = 1'b1;
				cmd.addr_sel = SEL_NB;
			end
			S_WR_A: begin
				cmd.mem_en   = 1'b1;
				cmd.mem_we   = 1'b1;
				cmd.addr_sel = SEL_NB;
			end
			S_WR_B: begin
				cmd.mem_en   = 1'b1;
				cmd.mem_we   = 1'b1;
				cmd.addr_sel = SEL_OTHER;
			end
			S_FIN: begin
				cmd.load_out = slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (status.range_err) begin
							state_q <= S_FIN;
						end else begin
							case (status.kind)
								KIND_LOAD_BYTE:  state_q <= S_LOAD;
								KIND_READ_BYTE:  state_q <= S_RDB;
								KIND_READ_ENTRY: state_q <= S_RD_LO;
								// fat16 writes whole bytes, no merge read needed
								default:         state_q <= status.fat16 ? S_WR_A : S_RMW_RD;
							endcase
						end
					end
				end
				S_LOAD:   state_q <= S_FIN;
				S_RDB:    state_q <= S_FIN;
				S_RD_LO:  state_q <= S_RD_HI;
				S_RD_HI:  state_q <= S_FIN;
				S_RMW_RD: state_q <= S_WR_A;
				S_WR_A:   state_q <= S_WR_B;
				S_WR_B:   state_q <= S_FIN;
				S_FIN: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`FATET_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_valid && in_ready, !in_ready, "ready after accept")
	`FATET_ASSERT_NOW(a_load_slot_free, clk, arst_n, cmd.load_out,
		!out_valid || out_ready, "result overwritten")
	`FATET_ASSERT_NEXT(a_load_valid, clk, arst_n, cmd.load_out, out_valid, "result lost")
	`FATET_ASSERT_NOW(a_no_mem_idle, clk, arst_n, state_q == S_IDLE || state_q == S_FIN,
		!cmd.mem_en, "memory access outside item")

endmodule

>>> rtl/core/fatet_dpath.sv
// ---------------------------------------------------------------------------
// fatet_dpath
// table memory, address generation, nibble merge and result register
// ---------------------------------------------------------------------------
module fatet_dpath #(
	parameter int unsigned TABLE_BYTES = 16384
) (
	input  logic               clk,
	input  logic [1:0]         kind,
	input  logic [13:0]        entry_index,
	input  logic [13:0]        byte_address,
	input  logic [7:0]         byte_data,
	input  logic [15:0]        new_value,
	input  logic               fat16,
	input  fatet_pkg::cmd_t    cmd,
	output fatet_pkg::status_t status,
	output logic [15:0]        entry_value,
	output logic [7:0]         byte_out,
	output logic               is_free,
	output logic               is_defect,
	output logic               end_of_chain,
	output logic               range_error
);
	import fatet_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_BYTES);
	localparam logic [LIM_W-1:0] LIMIT = LIM_W'(TABLE_BYTES);

	logic [7:0]    table_q [TABLE_BYTES];
	logic [7:0]    rdata_q;
	logic [7:0]    lo_q;
	logic [AW-1:0] addr_q;
	logic          odd_q;
	logic [15:0]   nv_q;
	logic [7:0]    bdata_q;
	logic [1:0]    kind_q;
	logic          range_q;

	logic [15:0]   entry_value_q;
	logic [7:0]    byte_out_q;
	logic          is_free_q;
	logic          is_defect_q;
	logic          end_of_chain_q;
	logic          range_error_q;

	logic [15:0]   idx3;
	logic [15:0]   e_addr;
	logic [15:0]   addr_full;
	logic          byte_req;
	logic [AW-1:0] addr_hi;
	logic          nb_hi;
	logic [15:0]   v_wr;
	logic [15:0]   v_rd;
	logic [15:0]   v_res;
	logic [7:0]    wlo;
	logic [7:0]    whi;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;

	// fat12 entries start at 3n/2, fat16 at 2n
	always_comb begin
		idx3      = 16'(entry_index) + 16'({entry_index, 1'b0});
		e_addr    = fat16 ? {1'b0, entry_index, 1'b0} : {1'b0, idx3[15:1]};
		byte_req  = (kind == KIND_LOAD_BYTE) || (kind == KIND_READ_BYTE);
		addr_full = byte_req ? {2'b00, byte_address} : e_addr;
		status.kind  = kind;
		status.fat16 = fat16;
		if (byte_req) begin
			status.range_err = (LIM_W'(byte_address) >= LIMIT);
		end else begin
			status.range_err = ((LIM_W'(e_addr) + LIM_W'(1)) >= LIMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			addr_q  <= addr_full[AW-1:0];
			odd_q   <= entry_index[0];
			nv_q    <= new_value;
			bdata_q <= byte_data;
			kind_q  <= kind;
			range_q <= status.range_err;
		end
		if (cmd.cap_lo) begin
			lo_q <= rdata_q;
		end
	end

	// the neighbouring entry shares the high byte for even fat12 entries
	always_comb begin
		addr_hi = addr_q + AW'(1);
		nb_hi   = !fat16 && !odd_q;
		v_wr    = fat16 ? nv_q : (nv_q & FAT12_MASK);
		wlo     = (fat16 || !odd_q) ? v_wr[7:0] : {v_wr[3:0], rdata_q[3:0]};
		if (fat16) begin
			whi = v_wr[15:8];
		end else if (!odd_q) begin
			whi = {rdata_q[7:4], v_wr[11:8]};
		end else begin
			whi = v_wr[11:4];
		end
		case (cmd.addr_sel)
			SEL_BYTE: begin
				mem_addr  = addr_q;
				mem_wdata = bdata_q;
			end
			SEL_LO: begin
				mem_addr  = addr_q;
				mem_wdata = wlo;
			end
			SEL_HI: begin
				mem_addr  = addr_hi;
				mem_wdata = whi;
			end
			SEL_NB: begin
				mem_addr  = nb_hi ? addr_hi : addr_q;
				mem_wdata = nb_hi ? whi : wlo;
			end
			SEL_OTHER: begin
				mem_addr  = nb_hi ? addr_q : addr_hi;
				mem_wdata = nb_hi ? wlo : whi;
			end
			default: begin
				mem_addr  = addr_q;
				mem_wdata = bdata_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_en) begin
			if (cmd.mem_we) begin
				table_q[mem_addr] <= mem_wdata;
			end else begin
				rdata_q <= table_q[mem_addr];
			end
		end
	end

	always_comb begin
		if (fat16) begin
			v_rd = {rdata_q, lo_q};
		end else if (!odd_q) begin
			v_rd = {4'h0, rdata_q[3:0], lo_q};
		end else begin
			v_rd = {4'h0, rdata_q, lo_q[7:4]};
		end
		v_res = (kind_q == KIND_WRITE_ENTRY) ? v_wr : v_rd;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			entry_value_q  <= '0;
			byte_out_q     <= '0;
			is_free_q      <= 1'b0;
			is_defect_q    <= 1'b0;
			end_of_chain_q <= 1'b0;
			range_error_q  <= range_q;
			if (!range_q) begin
				case (kind_q)
					KIND_LOAD_BYTE: begin
						byte_out_q <= '0;
					end
					KIND_READ_BYTE: begin
						byte_out_q <= rdata_q;
					end
					default: begin
						entry_value_q  <= v_res;
						is_free_q      <= (v_res == '0);
						is_defect_q    <= fat16 ? (v_res == FAT16_BAD) : (v_res == FAT12_BAD);
						end_of_chain_q <= fat16 ? (v_res >= FAT16_EOC) : (v_res >= FAT12_EOC);
					end
				endcase
			end
		end
	end

	assign entry_value  = entry_value_q;
	assign byte_out     = byte_out_q;
	assign is_free      = is_free_q;
	assign is_defect    = is_defect_q;
	assign end_of_chain = end_of_chain_q;
	assign range_error  = range_error_q;

endmodule

>>> rtl/core/fat12_fat16_entry_table.sv
// ---------------------------------------------------------------------------
// fat12_fat16_entry_table
// FAT12/FAT16 cluster table store with byte and entry access
// ---------------------------------------------------------------------------
// Input beats (kind, entry_index, byte_address, byte_data, new_value) are
// taken on in_valid/in_ready; one result beat per input comes out on
// out_valid/out_ready. Items are handled one at a time on a single-port byte
// memory; besides an accept step and a result step, an item makes the memory
// accesses it needs: none out of range, one for a byte load or read, low and
// high byte reads for an entry read, two byte writes for a FAT16 write, and
// for a FAT12 write a neighbour byte read, a merged write and a plain write.
// The result appears on out_valid at the edge that ends the item. A stalled
// receiver holds the result in the output register; the next item is still
// taken and worked on, and waits in its last step until the register frees.
// fat16_mode sits at APB byte address 0 and must be written only while idle;
// the block does not enforce this. Reset clears the sequencer, the output
// valid and fat16_mode; the table contents are undefined until written.
// ---------------------------------------------------------------------------
module fat12_fat16_entry_table #(
	parameter int unsigned TABLE_BYTES = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [13:0] entry_index,
	input  logic [13:0] byte_address,
	input  logic [7:0]  byte_data,
	input  logic [15:0] new_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] entry_value,
	output logic [7:0]  byte_out,
	output logic        is_free,
	output logic        is_defect,
	output logic        end_of_chain,
	output logic        range_error
);
	import fatet_pkg::*;

	logic    fat16_q;
	logic    reg_sel;
	cmd_t    cmd;
	status_t status;

	assign pready  = 1'b1;
	assign reg_sel = ({paddr[2], 2'b00} == REG_FAT16_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fat16_q <= 1'b0;
		end else if (psel && penable && pwrite && reg_sel) begin
			fat16_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = {31'b0, fat16_q};
		end
	end

	fatet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	fatet_dpath #(
		.TABLE_BYTES (TABLE_BYTES)
	) u_dpath (
		.clk          (clk),
		.kind         (kind),
		.entry_index  (entry_index),
		.byte_address (byte_address),
		.byte_data    (byte_data),
		.new_value    (new_value),
		.fat16        (fat16_q),
		.cmd          (cmd),
		.status       (status),
		.entry_value  (entry_value),
		.byte_out     (byte_out),
		.is_free      (is_free),
		.is_defect    (is_defect),
		.end_of_chain (end_of_chain),
		.range_error  (range_error)
	);

endmodule

>>> bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the fat12/fat16 cluster table store
// ---------------------------------------------------------------------------
// Drives byte loads, byte reads and entry reads/writes in both entry widths.
// A shadow copy of the table predicts every result beat, which is checked
// field by field in order. Reads only ever touch bytes that were loaded.
// Both handshake sides idle in random bursts. A final stretch runs without
// any idling.
// ---------------------------------------------------------------------------
module tb_top;
	import fatet_pkg::*;

	localparam int unsigned TABLE_BYTES = 16384;
	localparam int unsigned CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [13:0] entry_index;
		logic [13:0] byte_address;
		logic [7:0]  byte_data;
		logic [15:0] new_value;
	} access_t;

	typedef struct packed {
		logic [15:0] entry_value;
		logic [7:0]  byte_out;
		logic        is_free;
		logic        is_defect;
		logic        end_of_chain;
		logic        range_error;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  kind = '0;
	logic [13:0] entry_index = '0;
	logic [13:0] byte_address = '0;
	logic [7:0]  byte_data = '0;
	logic [15:0] new_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] entry_value;
	logic [7:0]  byte_out;
	logic        is_free;
	logic        is_defect;
	logic        end_of_chain;
	logic        range_error;

	// shadow of the table and the mode register
	logic [7:0]  shadow_bytes [TABLE_BYTES];
	bit          byte_loaded [TABLE_BYTES];
	logic        wide_entries = 1'b0;
	answer_t     table_answers [$];

	int          errors = 0;
	int          beats_sent = 0;
	int          entry_beats = 0;
	int          range_beats = 0;
	bit          source_idle_on = 1'b0;
	bit          sink_idle_on = 1'b0;
	int          sink_hold = 0;
	int unsigned cycle_count = 0;

	fat12_fat16_entry_table #(
		.TABLE_BYTES(TABLE_BYTES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.entry_index(entry_index),
		.byte_address(byte_address),
		.byte_data(byte_data),
		.new_value(new_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.entry_value(entry_value),
		.byte_out(byte_out),
		.is_free(is_free),
		.is_defect(is_defect),
		.end_of_chain(end_of_chain),
		.range_error(range_error)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycle_count);
			$display("[fat12_fat16_entry_table] ERROR");
			$finish;
		end
	end

	function automatic int unsigned entry_offset(logic [13:0] idx);
		int unsigned n;
		n = {18'b0, idx};
		return wide_entries ? n * 2 : (n * 3) >> 1;
	endfunction

	function automatic access_t make_access(logic [1:0] k, logic [13:0] idx,
			logic [13:0] addr, logic [7:0] data, logic [15:0] nv);
		access_t it;
		it.kind = k;
		it.entry_index = idx;
		it.byte_address = addr;
		it.byte_data = data;
		it.new_value = nv;
		return it;
	endfunction

	// predicts one result beat and updates the shadow table
	function automatic answer_t table_access(access_t it);
		answer_t     a;
		int unsigned e;
		logic [15:0] v;
		logic [15:0] bad;
		logic [15:0] eoc;
		a = '0;
		if (it.kind == KIND_LOAD_BYTE || it.kind == KIND_READ_BYTE) begin
			if (it.byte_address >= TABLE_BYTES) begin
				a.range_error = 1'b1;
			end else if (it.kind == KIND_LOAD_BYTE) begin
				shadow_bytes[it.byte_address] = it.byte_data;
				byte_loaded[it.byte_address] = 1'b1;
			end else begin
				a.byte_out = shadow_bytes[it.byte_address];
			end
			return a;
		end
		e = entry_offset(it.entry_index);
		if (e + 1 >= TABLE_BYTES) begin
			a.range_error = 1'b1;
			return a;
		end
		if (it.kind == KIND_READ_ENTRY) begin
			if (wide_entries)
				v = {shadow_bytes[e + 1], shadow_bytes[e]};
			else if (!it.entry_index[0])
				v = {4'h0, shadow_bytes[e + 1][3:0], shadow_bytes[e]};
			else
				v = {4'h0, shadow_bytes[e + 1], shadow_bytes[e][7:4]};
		end else begin
			if (wide_entries) begin
				v = it.new_value;
				shadow_bytes[e] = v[7:0];
				shadow_bytes[e + 1] = v[15:8];
			end else begin
				// top nibble dropped, shared byte keeps the neighbour's nibble
				v = it.new_value & FAT12_MASK;
				if (!it.entry_index[0]) begin
					shadow_bytes[e] = v[7:0];
					shadow_bytes[e + 1][3:0] = v[11:8];
				end else begin
					shadow_bytes[e + 1] = v[11:4];
					shadow_bytes[e][7:4] = v[3:0];
				end
			end
			byte_loaded[e] = 1'b1;
			byte_loaded[e + 1] = 1'b1;
		end
		bad = wide_entries ? FAT16_BAD : FAT12_BAD;
		eoc = wide_entries ? FAT16_EOC : FAT12_EOC;
		a.entry_value = v;
		a.is_free = (v == 16'h0000);
		a.is_defect = (v == bad);
		a.end_of_chain = (v >= eoc);
		return a;
	endfunction

	// random access into the low and high windows of the table, with some entries
	// past its end; anything that would read an unloaded byte becomes a load of that byte
	function automatic access_t random_access();
		access_t     it;
		int unsigned pick;
		int unsigned e;
		int unsigned idx_hi;
		bit          need_lo;
		bit          need_hi;
		it.kind = KIND_LOAD_BYTE;
		it.entry_index = 14'($urandom_range(0, 16383));
		it.byte_address = 14'($urandom_range(0, 16383));
		it.byte_data = 8'($urandom_range(0, 255));
		it.new_value = 16'($urandom_range(0, 65535));
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			it.kind = (pick < 25) ? KIND_LOAD_BYTE : KIND_READ_BYTE;
			if ($urandom_range(0, 4) == 0)
				it.byte_address = 14'($urandom_range(TABLE_BYTES - 512, TABLE_BYTES - 1));
			else
				it.byte_address = 14'($urandom_range(0, 511));
			if (it.kind == KIND_READ_BYTE && !byte_loaded[it.byte_address])
				it.kind = KIND_LOAD_BYTE;
			return it;
		end
		it.kind = (pick < 75) ? KIND_READ_ENTRY : KIND_WRITE_ENTRY;
		idx_hi = wide_entries ? 8191 : 10921;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			it.entry_index = 14'($urandom_range(idx_hi + 1, 16383));
		else if (pick < 3)
			it.entry_index = 14'($urandom_range(wide_entries ? 7936 : 10582, idx_hi));
		else
			it.entry_index = 14'($urandom_range(0, wide_entries ? 254 : 340));
		if (it.entry_index > idx_hi)
			return it;
		e = entry_offset(it.entry_index);
		need_lo = (it.kind == KIND_READ_ENTRY) || (!wide_entries && it.entry_index[0]);
		need_hi = (it.kind == KIND_READ_ENTRY) || (!wide_entries && !it.entry_index[0]);
		if (need_lo && !byte_loaded[e]) begin
			it.kind = KIND_LOAD_BYTE;
			it.byte_address = 14'(e);
		end else if (need_hi && !byte_loaded[e + 1]) begin
			it.kind = KIND_LOAD_BYTE;
			it.byte_address = 14'(e + 1);
		end
		return it;
	endfunction

	task automatic send_beat(input access_t it);
		int      gap;
		answer_t a;
		gap = 0;
		if (source_idle_on && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 5);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= it.kind;
		entry_index <= it.entry_index;
		byte_address <= it.byte_address;
		byte_data <= it.byte_data;
		new_value <= it.new_value;
		do @(posedge clk); while (!in_ready);
		a = table_access(it);
		table_answers.push_back(a);
		beats_sent++;
		if (it.kind == KIND_READ_ENTRY || it.kind == KIND_WRITE_ENTRY)
			entry_beats++;
		if (a.range_error)
			range_beats++;
	endtask

	// stop sending and wait for every outstanding result
	task automatic settle_table();
		@(negedge clk);
		in_valid <= 1'b0;
		while (table_answers.size() != 0) @(posedge clk);
	endtask

	task automatic set_entry_width(input logic mode);
		settle_table();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_FAT16_MODE;
		pwdata <= {31'b0, mode};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		wide_entries = mode;
		// psel stays up: straight into a read-back setup
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[0] !== mode) begin
			$error("fat16_mode readback: expected %0d, actual %0d", mode, prdata[0]);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (sink_hold > 0) begin
			out_ready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
			out_ready <= 1'b0;
			sink_hold <= $urandom_range(0, 4);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && out_valid && out_ready) begin
			if (table_answers.size() == 0) begin
				$error("result beat with no access outstanding");
				errors++;
			end else begin
				want = table_answers.pop_front();
				if (entry_value !== want.entry_value) begin
					$error("entry_value: expected %h, actual %h", want.entry_value, entry_value);
					errors++;
				end
				if (byte_out !== want.byte_out) begin
					$error("byte_out: expected %h, actual %h", want.byte_out, byte_out);
					errors++;
				end
				if (is_free !== want.is_free) begin
					$error("is_free: expected %b, actual %b", want.is_free, is_free);
					errors++;
				end
				if (is_defect !== want.is_defect) begin
					$error("is_defect: expected %b, actual %b", want.is_defect, is_defect);
					errors++;
				end
				if (end_of_chain !== want.end_of_chain) begin
					$error("end_of_chain: expected %b, actual %b",
						want.end_of_chain, end_of_chain);
					errors++;
				end
				if (range_error !== want.range_error) begin
					$error("range_error: expected %b, actual %b",
						want.range_error, range_error);
					errors++;
				end
			end
		end
	end

	// packed entries: defect, end of chain, free, nibble merges both ways
	task automatic test_fat12_entries();
		set_entry_width(1'b0);
		source_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		send_beat(make_access(KIND_LOAD_BYTE, 0, 0, 8'hf7, 16'h0000));
		send_beat(make_access(KIND_LOAD_BYTE, 0, 1, 8'h8f, 16'h0000));
		send_beat(make_access(KIND_LOAD_BYTE, 0, 2, 8'hff, 16'h0000));
		send_beat(make_access(KIND_LOAD_BYTE, 0, 3, 8'h00, 16'h0000));
		send_beat(make_access(KIND_LOAD_BYTE, 0, 4, 8'h00, 16'h0000));
		send_beat(make_access(KIND_LOAD_BYTE, 0, 5, 8'h00, 16'h0000));
		send_beat(make_access(KIND_READ_ENTRY, 0, 0, 8'h00, 16'h0000));
		send_beat(make_access(KIND_READ_ENTRY, 1, 0, 8'h00, 16'h0000));
		send_beat(make_access(KIND_READ_ENTRY, 2, 0, 8'h00, 16'h0000));
		// top nibble dropped: 0xfff7 lands as the packed defect code
		send_beat(make_access(KIND_WRITE_ENTRY, 3, 0, 8'h00, 16'hfff7));
		send_beat(make_access(KIND_READ_ENTRY, 2, 0, 8'h00, 16'h0000));
		send_beat(make_access(KIND_WRITE_ENTRY, 2, 0, 8'h00, 16'h0abc));
		send_beat(make_access(KIND_READ_ENTRY, 3, 0, 8'h00, 16'h0000));
		send_beat(make_access(KIND_READ_BYTE, 0, 4, 8'h00, 16'h0000));
	endtask

	// last bytes of the store, the last fat12 entry and entries past it
	task automatic test_table_boundary();
		send_beat(make_access(KIND_LOAD_BYTE, 0, 16381, 8'h5a, 16'h0000));
		send_beat(make_access(KIND_LOAD_BYTE, 0, 16382, 8'hc3, 16'h0000));
		send_beat(make_access(KIND_LOAD_BYTE, 0, 16383, 8'hff, 16'h0000));
		send_beat(make_access(KIND_READ_BYTE, 0, 16383, 8'h00, 16'h0000));
		send_beat(make_access(KIND_READ_ENTRY, 10921, 0, 8'h00, 16'h0000));
		send_beat(make_access(KIND_WRITE_ENTRY, 10922, 0, 8'h00, 16'hffff));
		send_beat(make_access(KIND_READ_ENTRY, 16383, 16383, 8'hff, 16'hffff));
	endtask

	task automatic test_fat16_entries();
		set_entry_width(1'b1);
		send_beat(make_access(KIND_WRITE_ENTRY, 0, 0, 8'h00, 16'hfff7));
		send_beat(make_access(KIND_WRITE_ENTRY, 1, 0, 8'h00, 16'hfff8));
		send_beat(make_access(KIND_WRITE_ENTRY, 2, 0, 8'h00, 16'h0000));
		send_beat(make_access(KIND_READ_ENTRY, 8191, 0, 8'h00, 16'h0000));
		send_beat(make_access(KIND_READ_ENTRY, 8192, 0, 8'h00, 16'h0000));
	endtask

	task automatic test_random_traffic(input int n, input logic mode, input bit idle);
		set_entry_width(mode);
		source_idle_on = idle;
		sink_idle_on = idle;
		repeat (n) begin
			send_beat(random_access());
			if ($urandom_range(0, 99) == 0)
				settle_table();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_fat12_entries();
		test_table_boundary();
		test_fat16_entries();
		test_random_traffic(180, 1'b0, 1'b1);
		test_random_traffic(180, 1'b1, 1'b1);
		test_random_traffic(100, 1'b0, 1'b0);
		test_random_traffic(180, 1'b1, 1'b1);
		test_random_traffic(180, 1'b0, 1'b1);
		test_random_traffic(130, 1'b1, 1'b0);

		settle_table();
		repeat (20) @(posedge clk);
		if (table_answers.size() != 0) begin
			$error("%0d results never arrived", table_answers.size());
			errors++;
		end
		$display("covered %0d beats: %0d entry accesses, %0d out of range",
			beats_sent, entry_beats, range_beats);
		$display("both entry widths, nibble merges and the top of the table exercised");
		if (errors == 0)
			$display("[fat12_fat16_entry_table] OK");
		else
			$display("[fat12_fat16_entry_table] ERROR");
		$finish;
	end

endmodule
